[rtl/core/clr_pkg.sv]
// ----------------------------------------------------------------------------
// clr_pkg
// Shared types, widths and codes of the clipped line rasterizer.
// ----------------------------------------------------------------------------
package clr_pkg;

  // coordinate width, two's complement
  localparam int COORD_BITS = 13;

  // endpoint difference, error accumulator and point count widths
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 1;
  localparam int COUNT_BITS = COORD_BITS + 1;

  // framebuffer widths
  localparam int DIM_BITS   = 12;
  localparam int COLOR_BITS = 32;
  localparam int ADDR_BITS  = 24;

  // compare width for clipping against the screen size
  localparam int CMP_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

  // stream payload widths, rounded up to whole bytes
  localparam int S_DATA_RAW  = 4 * COORD_BITS;
  localparam int S_DATA_BITS = ((S_DATA_RAW + 7) / 8) * 8;
  localparam int M_DATA_RAW  = 2 * COORD_BITS + ADDR_BITS + COLOR_BITS;
  localparam int M_DATA_BITS = ((M_DATA_RAW + 7) / 8) * 8;

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_DRAW_COLOR    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [1:0]            step_t;

  localparam step_t STEP_NEG  = -2'sd1;
  localparam step_t STEP_ZERO = 2'sd0;
  localparam step_t STEP_POS  = 2'sd1;

  // one command held in the input stage
  typedef struct packed {
    opcode_t op;
    coord_t  start_x;
    coord_t  start_y;
    coord_t  end_x;
    coord_t  end_y;
  } line_cmd_t;

  // current point of the line walker
  typedef struct packed {
    logic   emit;
    coord_t x;
    coord_t y;
    logic   last;
  } point_t;

  // move a coordinate by -1, 0 or +1, wrapping at the coordinate width
  function automatic coord_t step_coord(coord_t c, step_t s);
    coord_t ext;
    ext = coord_t'({{(COORD_BITS-2){s[1]}}, s});
    return c + ext;
  endfunction

endpackage

[rtl/core/clr_stepper.sv]
// ----------------------------------------------------------------------------
// clr_stepper
// Line state and the per-point error update: loads endpoints, then walks
// one point per advance command along the major axis.
// ----------------------------------------------------------------------------
module clr_stepper import clr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,   // command in cmd is processed this cycle
  input  line_cmd_t cmd,
  output point_t    point
);

  coord_t                 cur_x;
  coord_t                 cur_y;
  logic [ERR_BITS-1:0]    err_acc;
  logic [COORD_BITS-1:0]  abs_dx;
  logic [COORD_BITS-1:0]  abs_dy;
  step_t                  step_x;
  step_t                  step_y;
  logic                   x_major;
  logic [COUNT_BITS-1:0]  points_left;

  // load path: deltas, signs and major axis from the endpoints
  logic signed [DIFF_BITS-1:0] ld_dx;
  logic signed [DIFF_BITS-1:0] ld_dy;
  logic [COORD_BITS-1:0]       ld_abs_dx;
  logic [COORD_BITS-1:0]       ld_abs_dy;
  step_t                       ld_step_x;
  step_t                       ld_step_y;
  logic                        ld_x_major;
  logic [COORD_BITS-1:0]       ld_major;

  always_comb begin
    ld_dx = {cmd.end_x[COORD_BITS-1], cmd.end_x} - {cmd.start_x[COORD_BITS-1], cmd.start_x};
    ld_dy = {cmd.end_y[COORD_BITS-1], cmd.end_y} - {cmd.start_y[COORD_BITS-1], cmd.start_y};
    ld_abs_dx = ld_dx[DIFF_BITS-1] ? COORD_BITS'(-ld_dx) : COORD_BITS'(ld_dx);
    ld_abs_dy = ld_dy[DIFF_BITS-1] ? COORD_BITS'(-ld_dy) : COORD_BITS'(ld_dy);
    ld_step_x = (ld_dx == '0) ? STEP_ZERO : (ld_dx[DIFF_BITS-1] ? STEP_NEG : STEP_POS);
    ld_step_y = (ld_dy == '0) ? STEP_ZERO : (ld_dy[DIFF_BITS-1] ? STEP_NEG : STEP_POS);
    ld_x_major = (ld_abs_dx >= ld_abs_dy);
    ld_major = ld_x_major ? ld_abs_dx : ld_abs_dy;
  end

  // advance path: error update and next point
  logic [COORD_BITS-1:0] major;
  logic [COORD_BITS-1:0] minor;
  logic [ERR_BITS-1:0]   err_sum;
  logic                  minor_step;
  logic [ERR_BITS-1:0]   err_acc_next;
  coord_t                cur_x_next;
  coord_t                cur_y_next;
  logic                  active;

  always_comb begin
    major = x_major ? abs_dx : abs_dy;
    minor = x_major ? abs_dy : abs_dx;
    err_sum = err_acc + ERR_BITS'(minor);
    minor_step = (err_sum >= ERR_BITS'(major));
    err_acc_next = minor_step ? (err_sum - ERR_BITS'(major)) : err_sum;
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    if (x_major) begin
      cur_x_next = step_coord(cur_x, step_x);
      if (minor_step) begin
        cur_y_next = step_coord(cur_y, step_y);
      end
    end else begin
      cur_y_next = step_coord(cur_y, step_y);
      if (minor_step) begin
        cur_x_next = step_coord(cur_x, step_x);
      end
    end
    active = (points_left != '0);
  end

  // point presented to the output side
  assign point.emit = (cmd.op == OP_ADVANCE) && active;
  assign point.x    = cur_x;
  assign point.y    = cur_y;
  assign point.last = (points_left == COUNT_BITS'(1));

  // line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      err_acc     <= '0;
      abs_dx      <= '0;
      abs_dy      <= '0;
      step_x      <= STEP_ZERO;
      step_y      <= STEP_ZERO;
      x_major     <= 1'b0;
      points_left <= '0;
    end else if (fire) begin
      if (cmd.op == OP_LOAD) begin
        cur_x       <= cmd.start_x;
        cur_y       <= cmd.start_y;
        abs_dx      <= ld_abs_dx;
        abs_dy      <= ld_abs_dy;
        step_x      <= ld_step_x;
        step_y      <= ld_step_y;
        x_major     <= ld_x_major;
        err_acc     <= ERR_BITS'(ld_major >> 1);
        points_left <= COUNT_BITS'(ld_major) + COUNT_BITS'(1);
      end else if (active) begin
        cur_x       <= cur_x_next;
        cur_y       <= cur_y_next;
        err_acc     <= err_acc_next;
        points_left <= points_left - COUNT_BITS'(1);
      end
    end
  end

  // error stays within the major delta while a line is active
  assert property (@(posedge clk) disable iff (rst)
    (points_left != '0) |-> (err_acc <= ERR_BITS'(major)))
    else $error("error accumulator exceeds major delta");

  // emitting the final point ends the line
  assert property (@(posedge clk) disable iff (rst)
    (fire && point.emit && point.last) |=> (points_left == '0))
    else $error("line still active after final point");

  // the major axis is never the shorter one
  assert property (@(posedge clk) disable iff (rst)
    x_major |-> (abs_dx >= abs_dy))
    else $error("x chosen as major axis with smaller delta");

endmodule

[rtl/core/clipped_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// clipped_line_rasterizer
// Incremental integer line rasterizer with screen clipping and framebuffer
// address generation.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries commands. tuser selects the kind: a load
//   (tuser low) takes both endpoints from tdata and gives no result; an
//   advance (tuser high) emits the next point of the active line, or nothing
//   once the line is done. The master stream carries one point per emitting advance:
//   coordinates, framebuffer address, colour, tuser as the visible flag and
//   tlast on the final point of the line.
//   A command is taken into an input register. Once the output register
//   is free, the line walker updates its error term and position, while
//   the clipping compare and the address multiply fill the output
//   register: a point reaches the master side through the input register
//   and then the output register, and one command is taken every cycle
//   unless the receiver stalls. Then the point waits in the output register
//   while the next command still enters the input register; only then is
//   tready dropped. Reset empties both stages, leaves no active line and sets
//   the screen to 640 by 480 with colour zero. Configuration is written
//   through cfg_we, cfg_index and cfg_data while the stream is idle.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer import clr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // commands
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [S_DATA_BITS-1:0]    s_tdata,   // start_x, start_y, end_x, end_y
  input  logic                      s_tuser,   // opcode
  // points
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [M_DATA_BITS-1:0]    m_tdata,   // point_x, point_y, pixel_address, pixel_value
  output logic                      m_tuser,   // visible
  output logic                      m_tlast,   // last_point
  // configuration
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [DIM_BITS-1:0]   screen_width;
  logic [DIM_BITS-1:0]   screen_height;
  logic [COLOR_BITS-1:0] draw_color;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DIM_BITS'(640);
      screen_height <= DIM_BITS'(480);
      draw_color    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[DIM_BITS-1:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[DIM_BITS-1:0];
        REG_DRAW_COLOR:    draw_color    <= cfg_data[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake between the two stages
  logic      in_valid;
  line_cmd_t cmd;
  logic      fire;

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= (s_tvalid && s_tready) || (in_valid && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd.op      <= opcode_t'(s_tuser);
      cmd.start_x <= s_tdata[0*COORD_BITS +: COORD_BITS];
      cmd.start_y <= s_tdata[1*COORD_BITS +: COORD_BITS];
      cmd.end_x   <= s_tdata[2*COORD_BITS +: COORD_BITS];
      cmd.end_y   <= s_tdata[3*COORD_BITS +: COORD_BITS];
    end
  end

  // line walker
  point_t point;

  clr_stepper u_stepper (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .cmd   (cmd),
    .point (point)
  );

  // clipping and framebuffer address
  logic [CMP_BITS-1:0]   ux;
  logic [CMP_BITS-1:0]   uy;
  logic [CMP_BITS-1:0]   wx;
  logic [CMP_BITS-1:0]   hy;
  logic                  vis;
  logic [2*CMP_BITS-1:0] row_base;
  logic [ADDR_BITS-1:0]  addr;

  always_comb begin
    ux = CMP_BITS'($unsigned(point.x));
    uy = CMP_BITS'($unsigned(point.y));
    wx = CMP_BITS'(screen_width);
    hy = CMP_BITS'(screen_height);
    vis = !point.x[COORD_BITS-1] && (ux < wx) && !point.y[COORD_BITS-1] && (uy < hy);
    row_base = uy * wx;
    addr = vis ? (ADDR_BITS'(row_base) + ADDR_BITS'(ux)) : '0;
  end

  // output register
  coord_t                out_x;
  coord_t                out_y;
  logic [ADDR_BITS-1:0]  out_addr;
  logic                  out_vis;
  logic [COLOR_BITS-1:0] out_color;
  logic                  out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= point.emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && point.emit) begin
      out_x     <= point.x;
      out_y     <= point.y;
      out_addr  <= addr;
      out_vis   <= vis;
      out_color <= draw_color;
      out_last  <= point.last;
    end
  end

  assign m_tdata = M_DATA_BITS'({out_color, out_addr, out_y, out_x});
  assign m_tuser = out_vis;
  assign m_tlast = out_last;

  // a visible point never has a negative coordinate
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_vis) |-> (!out_x[COORD_BITS-1] && !out_y[COORD_BITS-1]))
    else $error("visible point with negative coordinate");

  // clipped points carry a zero address
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_vis) |-> (out_addr == '0))
    else $error("clipped point with nonzero address");

  // commands are held back only by a stalled, full output register
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without downstream backpressure");

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clipped line rasterizer. Commands are streamed
// from a queue, with random gaps on the command side and random backpressure
// on the point side. Each accepted command runs through a behavioral line
// walker in the bench. The points that come out of the block are compared
// field by field, in order, with the predicted ones. The screen size and the
// colour are changed between phases, while the stream is quiet.
// ----------------------------------------------------------------------------
module tb;
  import clr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 4;       // settle time after the last point, with margin
  localparam int DRAIN_LIMIT   = 2000;    // cycles to wait for missing points
  localparam int HOLD_AT       = 150;     // accepted commands before long hold
  localparam int HOLD_CYCLES   = 64;

  // one predicted point
  typedef struct {
    coord_t                 x;
    coord_t                 y;
    logic [ADDR_BITS-1:0]   addr;
    logic                   vis;
    logic [COLOR_BITS-1:0]  color;
    logic                   last;
  } pixel_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [S_DATA_BITS-1:0]    s_tdata = '0;   // start_x, start_y, end_x, end_y
  logic                      s_tuser = 1'b0; // opcode
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [M_DATA_BITS-1:0]    m_tdata;        // point_x, point_y, pixel_address, pixel_value
  logic                      m_tuser;        // visible
  logic                      m_tlast;        // last_point
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_SCREEN_WIDTH;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  clipped_line_rasterizer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  line_cmd_t cmd_q[$];
  pixel_t    point_q[$];
  int        errors = 0;
  int        accepted_cmds = 0;
  bit        quiet = 1'b0;

  // walker state and screen setup mirrored in the bench
  logic [DIM_BITS-1:0]   scr_w = 12'd640;
  logic [DIM_BITS-1:0]   scr_h = 12'd480;
  logic [COLOR_BITS-1:0] ink = '0;
  coord_t                walk_x = '0;
  coord_t                walk_y = '0;
  logic [ERR_BITS-1:0]   err_term = '0;
  int                    run_dx = 0;
  int                    run_dy = 0;
  int                    dir_x = 0;
  int                    dir_y = 0;
  bit                    along_x = 1'b0;
  int                    pts_remaining = 0;

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // walk one command through the line stepper, queue the point it emits
  task automatic trace_command(line_cmd_t c);
    int     dx, dy, major, minor, px, py;
    pixel_t p;
    if (c.op == OP_LOAD) begin
      dx = $signed(c.end_x) - $signed(c.start_x);
      dy = $signed(c.end_y) - $signed(c.start_y);
      dir_x = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
      dir_y = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
      run_dx = (dx < 0) ? -dx : dx;
      run_dy = (dy < 0) ? -dy : dy;
      along_x = run_dx >= run_dy;
      major = along_x ? run_dx : run_dy;
      walk_x = c.start_x;
      walk_y = c.start_y;
      err_term = ERR_BITS'(major >> 1);
      pts_remaining = major + 1;
      return;
    end
    // advance with no line in progress is dropped
    if (pts_remaining == 0) return;
    px = walk_x;
    py = walk_y;
    p.x = walk_x;
    p.y = walk_y;
    p.vis = px >= 0 && px < int'(scr_w) && py >= 0 && py < int'(scr_h);
    p.addr = p.vis ? ADDR_BITS'(py * int'(scr_w) + px) : '0;
    p.color = ink;
    pts_remaining--;
    p.last = (pts_remaining == 0);
    point_q.push_back(p);
    major = along_x ? run_dx : run_dy;
    minor = along_x ? run_dy : run_dx;
    err_term = ERR_BITS'(int'(err_term) + minor);
    if (int'(err_term) >= major) begin
      err_term = ERR_BITS'(int'(err_term) - major);
      if (along_x) walk_y = walk_y + coord_t'(dir_y);
      else walk_x = walk_x + coord_t'(dir_x);
    end
    if (along_x) walk_x = walk_x + coord_t'(dir_x);
    else walk_y = walk_y + coord_t'(dir_y);
  endtask

  // command driver with random gaps
  line_cmd_t held_cmd;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        trace_command(held_cmd);
        accepted_cmds++;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 7);
        s_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        held_cmd = cmd_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= held_cmd.op;
        s_tdata <= S_DATA_BITS'({held_cmd.end_y, held_cmd.end_x,
                                 held_cmd.start_y, held_cmd.start_x});
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // point side backpressure, with one long hold to fill the pipeline
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && accepted_cmds >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // point monitor
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (point_q.size() == 0) begin
        report_mismatch("unexpected point x", 32'(m_tdata[0 +: COORD_BITS]), '0);
      end else begin
        want = point_q.pop_front();
        if (m_tdata[0 +: COORD_BITS] !== want.x)
          report_mismatch("point_x", 32'(m_tdata[0 +: COORD_BITS]), 32'(want.x));
        if (m_tdata[COORD_BITS +: COORD_BITS] !== want.y)
          report_mismatch("point_y", 32'(m_tdata[COORD_BITS +: COORD_BITS]), 32'(want.y));
        if (m_tdata[2*COORD_BITS +: ADDR_BITS] !== want.addr)
          report_mismatch("pixel_address", 32'(m_tdata[2*COORD_BITS +: ADDR_BITS]),
                          32'(want.addr));
        if (m_tdata[2*COORD_BITS+ADDR_BITS +: COLOR_BITS] !== want.color)
          report_mismatch("pixel_value", m_tdata[2*COORD_BITS+ADDR_BITS +: COLOR_BITS],
                          want.color);
        if (m_tuser !== want.vis) report_mismatch("visible", 32'(m_tuser), 32'(want.vis));
        if (m_tlast !== want.last) report_mismatch("last_point", 32'(m_tlast), 32'(want.last));
      end
    end
  end

  task automatic push_cmd(opcode_t op, int sx, int sy, int ex, int ey);
    line_cmd_t c;
    c.op = op;
    c.start_x = coord_t'(sx);
    c.start_y = coord_t'(sy);
    c.end_x = coord_t'(ex);
    c.end_y = coord_t'(ey);
    cmd_q.push_back(c);
  endtask

  task automatic push_advances(int n);
    repeat (n) push_cmd(OP_ADVANCE, $urandom, $urandom, $urandom, $urandom);
  endtask

  // pick an endpoint offset from a start, kept inside the coordinate range
  function automatic int offset_coord(int s, int span);
    int off, e;
    off = $urandom_range(0, 2 * span) - span;
    e = s + off;
    if (e > 4095 || e < -4096) e = s - off;
    return e;
  endfunction

  // random lines: mostly whole lines, half starting near the screen, some cut short,
  // some full range and some stray advances
  task automatic queue_random_lines(int target, int w, int h);
    int made, kind, span, sx, sy, ex, ey, pts, n;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        push_advances(1);
      end else begin
        if (kind == 1) begin
          sx = $signed(coord_t'($urandom));
          sy = $signed(coord_t'($urandom));
          ex = $signed(coord_t'($urandom));
          ey = $signed(coord_t'($urandom));
        end else begin
          if ($urandom_range(0, 1)) begin
            sx = $urandom_range(0, w + 16) - 8;
            sy = $urandom_range(0, h + 16) - 8;
          end else begin
            sx = $signed(coord_t'($urandom));
            sy = $signed(coord_t'($urandom));
          end
          span = ($urandom_range(0, 24) == 0) ? 300 : 12;
          ex = offset_coord(sx, span);
          ey = offset_coord(sy, span);
        end
        pts = ((ex > sx) ? ex - sx : sx - ex);
        if (((ey > sy) ? ey - sy : sy - ey) > pts) pts = (ey > sy) ? ey - sy : sy - ey;
        pts++;
        if (kind == 1 || kind == 2) n = $urandom_range(0, (pts < 6) ? pts : 6);
        else n = pts;
        push_cmd(OP_LOAD, sx, sy, ex, ey);
        push_advances(n);
        made += 1 + n;
        // stray advances after the line is done
        if (n == pts && $urandom_range(0, 3) == 0) push_advances($urandom_range(1, 2));
      end
    end
  endtask

  // wait until every command is taken and every point has come out
  task automatic wait_idle();
    int guard;
    // sample between edges so the driver's updates have settled
    while (cmd_q.size() > 0 || s_tvalid) @(negedge clk);
    guard = 0;
    while (point_q.size() > 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (point_q.size() > 0) begin
      $display("%0d expected points never arrived", point_q.size());
      errors++;
      point_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h,
                           logic [COLOR_BITS-1:0] color);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data <= CFG_DATA_BITS'(w);
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data <= CFG_DATA_BITS'(h);
    @(posedge clk);
    cfg_index <= REG_DRAW_COLOR;
    cfg_data <= color;
    @(posedge clk);
    cfg_we <= 1'b0;
    scr_w = w;
    scr_h = h;
    ink = color;
  endtask

  // stimulus phases
  initial begin
    int w, h;
    @(negedge rst);

    // directed, at reset screen size and colour
    push_advances(1);                              // no line yet
    push_cmd(OP_LOAD, 0, 0, 0, 0);                 // zero-length line
    push_advances(2);
    push_cmd(OP_LOAD, 0, 0, 3, 3);                 // equal deltas
    push_advances(4);
    push_cmd(OP_LOAD, 639, 479, 636, 481);         // crosses the screen edge
    push_advances(4);
    push_cmd(OP_LOAD, -4096, -4096, 4095, 4095);   // extreme endpoints
    push_advances(2);
    push_cmd(OP_LOAD, 4095, -4096, -4096, 4095);   // replaces the line in progress
    push_advances(2);
    push_cmd(OP_LOAD, -1, 2, 1, -3);               // steep, negative y
    push_advances(3);
    wait_idle();

    configure(12'd4095, 12'd4095, 32'hFFFF_FFFF);
    queue_random_lines(450, 4095, 4095);
    wait_idle();

    configure(12'd1, 12'd1, 32'hA5A5_5A5A);
    queue_random_lines(350, 1, 1);
    wait_idle();

    // empty screen: nothing may be visible
    configure(12'd0, 12'd0, $urandom);
    queue_random_lines(125, 16, 16);
    wait_idle();
    configure(12'd200, 12'd0, $urandom);
    queue_random_lines(125, 200, 16);
    wait_idle();

    w = $urandom_range(1, 4095);
    h = $urandom_range(1, 4095);
    configure(DIM_BITS'(w), DIM_BITS'(h), $urandom);
    queue_random_lines(450, (w > 600) ? 600 : w, (h > 600) ? 600 : h);
    wait_idle();

    // final stretch without gaps or stalls
    quiet = 1'b1;
    configure(12'd640, 12'd480, $urandom);
    queue_random_lines(400, 640, 480);
    wait_idle();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
rtl/core/clr_pkg.sv
rtl/core/clr_stepper.sv
rtl/core/clipped_line_rasterizer.sv
sim/tb.sv
